// ----- src/tfd_pkg.sv -----
// ----------------------------------------------------------------------------
// Texel format decode package
// Shared item types, configuration struct and codes for the texel decoder.
// ----------------------------------------------------------------------------
package tfd_pkg;

  localparam int PALETTE_DEPTH_DEFAULT = 256;
  localparam int CFG_IDX_W = 2;

  // Opcodes
  localparam logic OP_DECODE = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  // Pixel formats
  localparam logic [2:0] FMT_RGBA32 = 3'd0;
  localparam logic [2:0] FMT_RGB24  = 3'd1;
  localparam logic [2:0] FMT_1555   = 3'd2;
  localparam logic [2:0] FMT_IDX8   = 3'd3;
  localparam logic [2:0] FMT_IDX4   = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_ZERO   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_ONE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_EXPAND = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAL_16BIT    = 2'd3;

  localparam logic [7:0] ALPHA_ZERO_RESET = 8'd0;
  localparam logic [7:0] ALPHA_ONE_RESET  = 8'd128;

  typedef struct packed {
    logic        opcode;
    logic [31:0] memory_word;
    logic [2:0]  pixel_format;
    logic [4:0]  bit_position;
    logic [7:0]  palette_index;
  } req_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       format_error;
  } rsp_t;

  typedef struct packed {
    logic [7:0] alpha_zero;
    logic [7:0] alpha_one;
    logic       alpha_expand_mode;
    logic       palette_is_16bit;
  } cfg_t;

endpackage

// ----- src/texel_format_decode_core.sv -----
// ----------------------------------------------------------------------------
// Texel format decode core
// Unpacks fetched texture words into 8-bit RGBA texels, with palette lookup.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one item per texel fetch or palette write. A
//   decode item yields exactly one rsp item; a palette write yields none and
//   stores memory_word at palette_index, if below PALETTE_DEPTH, when accepted.
//   The cfg channel writes the four registers by index; cfg_ready is always
//   high and writes are expected only while the block is idle.
//   From req acceptance to rsp valid, an item passes first through the
//   registered palette read, then through the unpack into the result
//   register. Throughput is one item per cycle while the receiver does not
//   stall, set by the single palette read port, read once per accepted decode item.
//   When the receiver stalls, the result register holds and one more item
//   waits in the read stage; req_ready then drops until rsp_ready returns.
//   Synchronous reset empties both stages and restores register defaults;
//   palette contents are not cleared and must be written before use.
// ----------------------------------------------------------------------------
module texel_format_decode_core #(
  parameter int PALETTE_DEPTH = tfd_pkg::PALETTE_DEPTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  tfd_pkg::req_t                req,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output tfd_pkg::rsp_t                rsp,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                   cfg_data
);

  localparam int AW = $clog2(PALETTE_DEPTH);

  tfd_pkg::cfg_t cfg;

  logic        req_fire;
  logic [7:0]  idx;
  logic        idx_in_range;
  logic        wr_in_range;
  logic [31:0] pal_rd_data;

  logic        s1_valid;
  logic [2:0]  s1_format;
  logic [31:0] s1_word;
  logic [4:0]  s1_pos;
  logic        s1_in_range;
  logic        s1_adv;

  tfd_pkg::rsp_t unpacked;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alpha_zero        <= tfd_pkg::ALPHA_ZERO_RESET;
      cfg.alpha_one         <= tfd_pkg::ALPHA_ONE_RESET;
      cfg.alpha_expand_mode <= 1'b0;
      cfg.palette_is_16bit  <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tfd_pkg::CFG_ALPHA_ZERO:   cfg.alpha_zero        <= cfg_data;
        tfd_pkg::CFG_ALPHA_ONE:    cfg.alpha_one         <= cfg_data;
        tfd_pkg::CFG_ALPHA_EXPAND: cfg.alpha_expand_mode <= cfg_data[0];
        tfd_pkg::CFG_PAL_16BIT:    cfg.palette_is_16bit  <= cfg_data[0];
      endcase
    end
  end

  assign s1_adv    = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || s1_adv;
  assign req_fire  = req_valid && req_ready;

  // Palette index: the word shifted down by the bit position, masked by format.
  always_comb begin
    idx = 8'(req.memory_word >> req.bit_position);
    if (req.pixel_format == tfd_pkg::FMT_IDX4) begin
      idx = {4'd0, idx[3:0]};
    end
  end

  assign idx_in_range = {1'b0, idx} < 9'(PALETTE_DEPTH);
  assign wr_in_range  = {1'b0, req.palette_index} < 9'(PALETTE_DEPTH);

  tfd_palette #(
    .DEPTH (PALETTE_DEPTH),
    .AW    (AW)
  ) u_palette (
    .clk     (clk),
    .wr_en   (req_fire && req.opcode == tfd_pkg::OP_WRITE && wr_in_range),
    .wr_addr (req.palette_index[AW-1:0]),
    .wr_data (req.memory_word),
    .rd_en   (req_fire && req.opcode == tfd_pkg::OP_DECODE),
    .rd_addr (idx[AW-1:0]),
    .rd_data (pal_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_fire) begin
      s1_valid <= (req.opcode == tfd_pkg::OP_DECODE);
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire && req.opcode == tfd_pkg::OP_DECODE) begin
      s1_format   <= req.pixel_format;
      s1_word     <= req.memory_word;
      s1_pos      <= req.bit_position;
      s1_in_range <= idx_in_range;
    end
  end

  tfd_unpack u_unpack (
    .pixel_format (s1_format),
    .memory_word  (s1_word),
    .bit_position (s1_pos),
    .entry        (pal_rd_data),
    .entry_valid  (s1_in_range),
    .cfg          (cfg),
    .rsp          (unpacked)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rsp <= unpacked;
    end
  end

endmodule

// ----- src/tfd_palette.sv -----
// ----------------------------------------------------------------------------
// Texel format decode palette
// Single-port-write, single-port-read palette memory with registered read.
// ----------------------------------------------------------------------------
module tfd_palette #(
  parameter int DEPTH = tfd_pkg::PALETTE_DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/tfd_unpack.sv -----
// ----------------------------------------------------------------------------
// Texel format decode unpacker
// Combinational unpacking of a direct texel or a palette entry into RGBA.
// ----------------------------------------------------------------------------
module tfd_unpack (
  input  logic [2:0]   pixel_format,
  input  logic [31:0]  memory_word,
  input  logic [4:0]   bit_position,
  input  logic [31:0]  entry,
  input  logic         entry_valid,
  input  tfd_pkg::cfg_t cfg,
  output tfd_pkg::rsp_t rsp
);

  function automatic logic [7:0] widen5(logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] rgb_alpha(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                           tfd_pkg::cfg_t c);
    if (c.alpha_expand_mode && r == 8'd0 && g == 8'd0 && b == 8'd0) begin
      return 8'd0;
    end
    return c.alpha_zero;
  endfunction

  function automatic tfd_pkg::rsp_t split_1555(logic [15:0] h, tfd_pkg::cfg_t c);
    tfd_pkg::rsp_t t;
    t.red          = widen5(h[4:0]);
    t.green        = widen5(h[9:5]);
    t.blue         = widen5(h[14:10]);
    t.alpha        = h[15] ? c.alpha_one : rgb_alpha(t.red, t.green, t.blue, c);
    t.format_error = 1'b0;
    return t;
  endfunction

  function automatic tfd_pkg::rsp_t split_rgba32(logic [31:0] w);
    tfd_pkg::rsp_t t;
    t.red          = w[7:0];
    t.green        = w[15:8];
    t.blue         = w[23:16];
    t.alpha        = w[31:24];
    t.format_error = 1'b0;
    return t;
  endfunction

  logic [31:0] pal_word;

  // An index past the end of the palette reads as an all-zero entry.
  assign pal_word = entry_valid ? entry : 32'd0;

  always_comb begin
    rsp = '0;
    unique case (pixel_format)
      tfd_pkg::FMT_RGBA32: begin
        rsp = split_rgba32(memory_word);
      end
      tfd_pkg::FMT_RGB24: begin
        rsp = split_rgba32(memory_word);
        rsp.alpha = rgb_alpha(rsp.red, rsp.green, rsp.blue, cfg);
      end
      tfd_pkg::FMT_1555: begin
        // Any nonzero bit position selects the upper half of the word.
        rsp = split_1555((bit_position != 5'd0) ? memory_word[31:16] : memory_word[15:0],
                         cfg);
      end
      tfd_pkg::FMT_IDX8, tfd_pkg::FMT_IDX4: begin
        if (cfg.palette_is_16bit) begin
          rsp = split_1555(pal_word[15:0], cfg);
        end else begin
          rsp = split_rgba32(pal_word);
        end
      end
      default: begin
        rsp = '0;
        rsp.format_error = 1'b1;
      end
    endcase
  end

endmodule

// ----- src/tfd_checker.sv -----
// ----------------------------------------------------------------------------
// Texel format decode checker
// Port-level assertions for the texel decoder, bound to the top level.
// ----------------------------------------------------------------------------
module tfd_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input tfd_pkg::rsp_t rsp
);

  // A stalled result holds its value.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("rsp changed or dropped while stalled");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("rsp_valid high after reset");

  // An illegal format always carries a zero color.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.format_error |->
      rsp.red == 8'd0 && rsp.green == 8'd0 && rsp.blue == 8'd0 && rsp.alpha == 8'd0)
    else $error("format_error with nonzero color");

  // With the result register empty, the read stage can always move on.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("req_ready low while rsp is empty");

endmodule

bind texel_format_decode_core tfd_checker u_tfd_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
